// ===== design/analog_ladder_rotary_decoder_macros.svh =====
// Assertion macros shared by the rotary decoder modules.
// Needs clk and rst_n in the scope of each use.
`ifndef ANALOG_LADDER_ROTARY_DECODER_MACROS_SVH
`define ANALOG_LADDER_ROTARY_DECODER_MACROS_SVH

// Check a property at every edge outside reset.
`define ALRD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define ALRD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/alrd_pkg.sv =====
// Shared types, constants and state tables of the analog ladder rotary decoder.
// No dependencies.
package alrd_pkg;

    localparam int POSITION_BITS = 16;
    localparam int SAMPLE_BITS   = 10;
    localparam int CFG_BITS      = 10;
    localparam int CFG_IDX_BITS  = 3;
    localparam int STEPS_OUT_BITS = 16;
    localparam int CMP_BITS =
        ((SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS) + 2;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_A_LEVEL   = 3'd0,
        REG_B_LEVEL   = 3'd1,
        REG_AB_LEVEL  = 3'd2,
        REG_WINDOW    = 3'd3,
        REG_HALF_STEP = 3'd4
    } reg_idx_t;

    typedef enum logic {
        OP_POLL = 1'b0,
        OP_TAKE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CODE_NONE = 2'd0,
        CODE_B    = 2'd1,
        CODE_A    = 2'd2,
        CODE_AB   = 2'd3
    } code_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_PRESS = 2'd1,
        EV_CW    = 2'd2,
        EV_CCW   = 2'd3
    } ev_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'b00,
        DIR_CW   = 2'b01,
        DIR_CCW  = 2'b10
    } dir_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] a_level;
        logic [CFG_BITS-1:0] b_level;
        logic [CFG_BITS-1:0] ab_level;
        logic [CFG_BITS-1:0] window;
        logic                half_step;
    } cfg_t;

    // One classified item as it travels from front to back.
    typedef struct packed {
        op_t   op;
        logic  press;
        code_t code;
    } item_t;

    // Entry: {direction[1:0], unused, next phase[2:0]}; columns are contact codes.
    localparam logic [5:0] FULL_TAB [7][4] = '{
        '{6'h00, 6'h02, 6'h04, 6'h00},
        '{6'h03, 6'h00, 6'h01, 6'h10},
        '{6'h03, 6'h02, 6'h00, 6'h00},
        '{6'h03, 6'h02, 6'h01, 6'h00},
        '{6'h06, 6'h00, 6'h04, 6'h00},
        '{6'h06, 6'h05, 6'h00, 6'h20},
        '{6'h06, 6'h05, 6'h04, 6'h00}
    };

    localparam logic [5:0] HALF_TAB [6][4] = '{
        '{6'h03, 6'h02, 6'h01, 6'h00},
        '{6'h23, 6'h00, 6'h01, 6'h00},
        '{6'h13, 6'h02, 6'h00, 6'h00},
        '{6'h03, 6'h05, 6'h04, 6'h00},
        '{6'h03, 6'h03, 6'h04, 6'h10},
        '{6'h03, 6'h05, 6'h03, 6'h20}
    };

endpackage

// ===== design/alrd_if.sv =====
// Handshake channels of the rotary decoder: item, result and config write.
// Depends on alrd_pkg.
interface alrd_item_if import alrd_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface alrd_result_if import alrd_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [1:0]                event_res;
    logic [STEPS_OUT_BITS-1:0] pending_steps;

    modport source (output valid, output event_res, output pending_steps, input ready);
    modport sink   (input valid, input event_res, input pending_steps, output ready);
endinterface

interface alrd_cfg_if import alrd_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CFG_BITS-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/alrd_queue.sv =====
// Short queue of classified items between front and back.
// Depends on alrd_pkg and the assertion macros.
`include "analog_ladder_rotary_decoder_macros.svh"

module alrd_queue
    import alrd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

    item_t               slot_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                push, pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ALRD_ASSERT_ALWAYS(a_count_bound, count_reg <= FULL_CNT, "queue count beyond depth")
    `ALRD_ASSERT(a_count_track,
        count_reg == $past(count_reg) + CNT_BITS'($past(push)) - CNT_BITS'($past(pop)),
        "queue count out of step with push and pop")

endmodule

// ===== design/alrd_front.sv =====
// Front end: takes item beats and classifies each sample by the level windows.
// Depends on alrd_pkg.
module alrd_front
    import alrd_pkg::*;
(
    alrd_item_if.sink item,
    input  cfg_t      cfg,
    output logic      push_valid,
    input  logic      push_ready,
    output item_t     push_item
);

    logic signed [CMP_BITS-1:0] s_ext;
    logic                       hit_ab, hit_a, hit_b;

    // Open window: level - window < s < level + window, no wrap.
    function automatic logic in_window(input logic signed [CMP_BITS-1:0] s,
                                       input logic [CFG_BITS-1:0] level,
                                       input logic [CFG_BITS-1:0] half);
        logic signed [CMP_BITS-1:0] l_ext, w_ext;
        l_ext = $signed(CMP_BITS'(level));
        w_ext = $signed(CMP_BITS'(half));
        return (s > l_ext - w_ext) && (s < l_ext + w_ext);
    endfunction

    assign s_ext  = $signed(CMP_BITS'(item.sample));
    assign hit_ab = in_window(s_ext, cfg.ab_level, cfg.window);
    assign hit_a  = in_window(s_ext, cfg.a_level, cfg.window);
    assign hit_b  = in_window(s_ext, cfg.b_level, cfg.window);

    assign item.ready = push_ready;
    assign push_valid = item.valid;

    always_comb
    begin
        push_item.op    = op_t'(item.cmd);
        push_item.press = (CMP_BITS'(item.sample) <= CMP_BITS'(cfg.window));
        if (hit_ab)
        begin
            push_item.code = CODE_AB;
        end
        else if (hit_a)
        begin
            push_item.code = CODE_A;
        end
        else if (hit_b)
        begin
            push_item.code = CODE_B;
        end
        else
        begin
            push_item.code = CODE_NONE;
        end
    end

endmodule

// ===== design/alrd_back.sv =====
// Back end: steps the quadrature phase, keeps position and button state,
// and holds the result register. Depends on alrd_pkg and the assertion macros.
`include "analog_ladder_rotary_decoder_macros.svh"

module alrd_back
    import alrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        half_step,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  item_t       pop_item,
    alrd_result_if.source result
);

    localparam logic signed [POSITION_BITS-1:0] POS_MAX =
        {1'b0, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [POSITION_BITS-1:0] POS_MIN =
        {1'b1, {(POSITION_BITS-1){1'b0}}};

    logic [2:0]                      phase_reg, phase_next;
    logic signed [POSITION_BITS-1:0] steps_reg, steps_next;
    logic                            press_seen_reg, press_seen_next;
    logic                            press_taken_reg, press_taken_next;
    logic                            out_valid_reg;
    ev_t                             ev_reg, ev_next;
    logic [STEPS_OUT_BITS-1:0]       out_steps_reg;
    logic                            pop;
    logic [2:0]                      row;
    logic [5:0]                      nx;
    dir_t                            dir;

    assign pop_ready = !out_valid_reg || result.ready;
    assign pop       = pop_valid && pop_ready;

    // Rows the selected table lacks fall back to the start phase.
    always_comb
    begin
        row = phase_reg;
        if (half_step)
        begin
            if (phase_reg >= 3'd6)
            begin
                row = '0;
            end
            nx = HALF_TAB[row][pop_item.code];
        end
        else
        begin
            if (phase_reg == 3'd7)
            begin
                row = '0;
            end
            nx = FULL_TAB[row][pop_item.code];
        end
        dir = dir_t'(nx[5:4]);
    end

    always_comb
    begin
        phase_next       = phase_reg;
        steps_next       = steps_reg;
        press_seen_next  = press_seen_reg;
        press_taken_next = press_taken_reg;
        ev_next          = EV_NONE;
        case (pop_item.op)
            OP_POLL:
            begin
                if (pop_item.press)
                begin
                    press_seen_next = 1'b1;
                end
                else
                begin
                    // Button released: drop the latched press once it has been taken.
                    if (press_taken_reg)
                    begin
                        press_seen_next  = 1'b0;
                        press_taken_next = 1'b0;
                    end
                    phase_next = nx[2:0];
                    if (dir == DIR_CW && steps_reg != POS_MAX)
                    begin
                        steps_next = steps_reg + 1'b1;
                    end
                    else if (dir == DIR_CCW && steps_reg != POS_MIN)
                    begin
                        steps_next = steps_reg - 1'b1;
                    end
                end
            end
            OP_TAKE:
            begin
                if (press_seen_reg && !press_taken_reg)
                begin
                    press_taken_next = 1'b1;
                    ev_next          = EV_PRESS;
                end
                else if (!steps_reg[POSITION_BITS-1] && steps_reg != '0)
                begin
                    steps_next = steps_reg - 1'b1;
                    ev_next    = EV_CW;
                end
                else if (steps_reg[POSITION_BITS-1])
                begin
                    steps_next = steps_reg + 1'b1;
                    ev_next    = EV_CCW;
                end
            end
            default:
            begin
                ev_next = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= '0;
            steps_reg       <= '0;
            press_seen_reg  <= 1'b0;
            press_taken_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg       <= phase_next;
                steps_reg       <= steps_next;
                press_seen_reg  <= press_seen_next;
                press_taken_reg <= press_taken_next;
            end
            if (pop_ready)
            begin
                out_valid_reg <= pop_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ev_reg        <= ev_next;
            out_steps_reg <= STEPS_OUT_BITS'(steps_next);
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.event_res     = ev_reg;
    assign result.pending_steps = out_steps_reg;

    `ALRD_ASSERT(a_steps_unit,
        steps_reg == $past(steps_reg) || steps_reg == $past(steps_reg) + 1'b1 ||
        steps_reg == $past(steps_reg) - 1'b1,
        "position moved by more than one")
    `ALRD_ASSERT(a_state_hold, !$past(pop) |-> $stable(steps_reg) && $stable(phase_reg),
        "decoder state changed with no item")
    `ALRD_ASSERT(a_taken_has_seen, press_taken_reg |-> press_seen_reg,
        "press taken without a press seen")

endmodule

// ===== design/analog_ladder_rotary_decoder.sv =====
// Top level of the analog ladder rotary decoder: config registers, front,
// queue and back. Depends on alrd_pkg, alrd_if, alrd_front, alrd_queue, alrd_back.
//
//   channel   dir  payload                          accepted when
//   item      in   cmd, sample                       valid && ready
//   result    out  event_res, pending_steps          valid && ready
//   cfg       in   index, data                       valid && ready (ready tied high)
//
// One item per cycle sustained while result.ready stays high; the front classifies
// each taken item into the queue, and the back pops it into the result register.
// item.ready follows only the queue fill: once result.ready drops, at most three more
// item beats are taken (one while streaming) before the input stalls.
// Reset clears the phase, position and press flags and loads the default levels.
module analog_ladder_rotary_decoder
    import alrd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    alrd_item_if.sink     item,
    alrd_result_if.source result,
    alrd_cfg_if.sink      cfg
);

    cfg_t  cfg_reg;
    logic  push_valid, push_ready;
    logic  pop_valid, pop_ready;
    item_t push_item, pop_item;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.a_level   <= CFG_BITS'(512);
            cfg_reg.b_level   <= CFG_BITS'(341);
            cfg_reg.ab_level  <= CFG_BITS'(292);
            cfg_reg.window    <= CFG_BITS'(20);
            cfg_reg.half_step <= 1'b0;
        end
        else if (cfg.valid)
        begin
            case (reg_idx_t'(cfg.index))
                REG_A_LEVEL:   cfg_reg.a_level   <= cfg.data;
                REG_B_LEVEL:   cfg_reg.b_level   <= cfg.data;
                REG_AB_LEVEL:  cfg_reg.ab_level  <= cfg.data;
                REG_WINDOW:    cfg_reg.window    <= cfg.data;
                REG_HALF_STEP: cfg_reg.half_step <= cfg.data[0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    alrd_front u_front (
        .item       (item),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    alrd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    alrd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .half_step (cfg_reg.half_step),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .result    (result)
    );

endmodule
